// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions of the JSON string
// unescaper: parser modes, result kinds, error codes and the job format
// that goes from the parser to the output sequencer.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_WAIT,
        MODE_STR,
        MODE_ESC,
        MODE_HEX,
        MODE_LOW_BS,
        MODE_LOW_U,
        MODE_LOW_HEX
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN   = 4'd0;
    localparam logic [3:0] ERR_UNTERM    = 4'd1;
    localparam logic [3:0] ERR_CTRL      = 4'd2;
    localparam logic [3:0] ERR_BAD_ESC   = 4'd3;
    localparam logic [3:0] ERR_SHORT_HEX = 4'd4;
    localparam logic [3:0] ERR_BAD_HEX   = 4'd5;
    localparam logic [3:0] ERR_NO_LOW    = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW   = 4'd7;
    localparam logic [3:0] ERR_LONE_LOW  = 4'd8;
    localparam logic [3:0] ERR_ESC_END   = 4'd9;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // One queued job: up to four result bytes, emitted from index 0 up to
    // last_idx. Close and error jobs carry a single zero byte.
    typedef struct packed {
        kind_t           kind;
        logic [3:0]      err;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic job_t single_job(input kind_t kind, input logic [3:0] err,
                                        input logic [7:0] b);
        job_t j;
        j = '0;
        j.kind     = kind;
        j.err      = err;
        j.last_idx = 2'd0;
        j.bytes[0] = b;
        return j;
    endfunction

    function automatic job_t utf8_job(input logic [20:0] cp);
        job_t j;
        j = '0;
        j.kind = KIND_DATA;
        j.err  = ERR_NONE;
        if (cp < 21'h80) begin
            j.last_idx = 2'd0;
            j.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            j.last_idx = 2'd1;
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            j.last_idx = 2'd2;
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            j.last_idx = 2'd3;
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
        end
        return j;
    endfunction

endpackage

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser: takes one raw byte per cycle while the job queue is not full, tracks
// escapes and \u digits, and pushes one job per byte that produces output into the job queue.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte [7:0]
    input  logic       s_tuser,   // end_flag [0]
    input  logic       queue_full,
    output push_t      push
);

    mode_t       mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  high_reg, high_next;

    logic        accept;
    logic        emit;
    job_t        job;
    logic        fail;
    logic [3:0]  fail_code;
    logic [4:0]  hx;
    logic [15:0] hex_cat;
    logic [20:0] cp_pair;
    logic [7:0]  c;
    logic        end_f;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign end_f    = s_tuser;
    assign hx       = hex_digit(c);
    assign hex_cat  = {hex_reg[11:0], hx[3:0]};
    assign cp_pair  = 21'h10000 + {1'b0, high_reg, hex_cat[9:0]};

    always_comb begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        cnt_next  = cnt_reg;
        high_next = high_reg;
        emit      = 1'b0;
        job       = single_job(KIND_DATA, ERR_NONE, 8'h00);
        fail      = 1'b0;
        fail_code = ERR_NONE;

        unique case (mode_reg)
            MODE_WAIT: begin
                if (!end_f && c == CH_QUOTE) begin
                    mode_next = MODE_STR;
                    hex_next  = '0;
                    cnt_next  = '0;
                    high_next = '0;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_OPEN;
                end
            end
            MODE_STR: begin
                if (end_f) begin
                    fail      = 1'b1;
                    fail_code = ERR_UNTERM;
                end else if (c == CH_QUOTE) begin
                    emit      = 1'b1;
                    job       = single_job(KIND_CLOSE, ERR_NONE, 8'h00);
                    mode_next = MODE_WAIT;
                end else if (c == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else if (c < CH_SPACE) begin
                    fail      = 1'b1;
                    fail_code = ERR_CTRL;
                end else begin
                    emit = 1'b1;
                    job  = single_job(KIND_DATA, ERR_NONE, c);
                end
            end
            MODE_ESC: begin
                if (end_f) begin
                    fail      = 1'b1;
                    fail_code = ERR_ESC_END;
                end else begin
                    mode_next = MODE_STR;
                    emit      = 1'b1;
                    case (c)
                        CH_QUOTE:  job = single_job(KIND_DATA, ERR_NONE, 8'h22);
                        CH_BSLASH: job = single_job(KIND_DATA, ERR_NONE, 8'h5C);
                        CH_SLASH:  job = single_job(KIND_DATA, ERR_NONE, 8'h2F);
                        CH_B:      job = single_job(KIND_DATA, ERR_NONE, 8'h08);
                        CH_F:      job = single_job(KIND_DATA, ERR_NONE, 8'h0C);
                        CH_N:      job = single_job(KIND_DATA, ERR_NONE, 8'h0A);
                        CH_R:      job = single_job(KIND_DATA, ERR_NONE, 8'h0D);
                        CH_T:      job = single_job(KIND_DATA, ERR_NONE, 8'h09);
                        CH_U: begin
                            emit      = 1'b0;
                            mode_next = MODE_HEX;
                            hex_next  = '0;
                            cnt_next  = '0;
                        end
                        default: begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            MODE_HEX, MODE_LOW_HEX: begin
                if (end_f) begin
                    fail      = 1'b1;
                    fail_code = (mode_reg == MODE_HEX) ? ERR_SHORT_HEX : ERR_NO_LOW;
                end else if (!hx[4]) begin
                    fail      = 1'b1;
                    fail_code = ERR_BAD_HEX;
                end else if (cnt_reg != 2'd3) begin
                    hex_next = hex_cat;
                    cnt_next = cnt_reg + 2'd1;
                end else begin
                    // Fourth digit: the escape is complete.
                    hex_next = '0;
                    cnt_next = '0;
                    if (mode_reg == MODE_HEX) begin
                        if (hex_cat[15:10] == HIGH_SURR_TAG) begin
                            high_next = hex_cat[9:0];
                            mode_next = MODE_LOW_BS;
                        end else if (hex_cat[15:10] == LOW_SURR_TAG) begin
                            fail      = 1'b1;
                            fail_code = ERR_LONE_LOW;
                        end else begin
                            emit      = 1'b1;
                            job       = utf8_job({5'd0, hex_cat});
                            mode_next = MODE_STR;
                        end
                    end else begin
                        if (hex_cat[15:10] != LOW_SURR_TAG) begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_LOW;
                        end else begin
                            emit      = 1'b1;
                            job       = utf8_job(cp_pair);
                            mode_next = MODE_STR;
                        end
                    end
                end
            end
            MODE_LOW_BS: begin
                if (end_f || c != CH_BSLASH) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_LOW;
                end else begin
                    mode_next = MODE_LOW_U;
                end
            end
            MODE_LOW_U: begin
                if (end_f || c != CH_U) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_LOW;
                end else begin
                    mode_next = MODE_LOW_HEX;
                    hex_next  = '0;
                    cnt_next  = '0;
                end
            end
            default: begin
                mode_next = MODE_WAIT;
            end
        endcase

        // Any error reports once and drops the parser back to waiting.
        if (fail) begin
            emit      = 1'b1;
            job       = single_job(KIND_ERROR, fail_code, 8'h00);
            mode_next = MODE_WAIT;
            hex_next  = '0;
            cnt_next  = '0;
            high_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_WAIT;
            hex_reg  <= '0;
            cnt_reg  <= '0;
            high_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cnt_reg  <= cnt_next;
            high_reg <= high_next;
        end
    end

    assign push.valid = accept && emit;
    assign push.job   = job;

endmodule

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small first-in first-out job queue in flip-flops between the parser and
// the output sequencer. Head entry is presented combinationally.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  full,
    input  logic  pop,
    output logic  rd_valid,
    output job_t  rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push.valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push.valid) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> rd_valid)
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy beyond its depth");

endmodule

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output sequencer: walks the head job's bytes one per cycle, unless the
// receiver stalls, into the output register; pops the job with its final byte.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        rd_valid,
    input  job_t        rd_data,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte [7:0], error_code [11:8], zero [15:12]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast    // last
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    kind_t      kind_reg;
    logic [3:0] err_reg;
    logic       last_reg;

    logic       load;
    logic       is_end;

    assign load   = rd_valid && (!valid_reg || m_tready);
    assign is_end = (idx_reg == rd_data.last_idx);
    assign pop    = load && is_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = is_end ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= rd_data.bytes[idx_reg];
            kind_reg <= rd_data.kind;
            err_reg  <= rd_data.err;
            last_reg <= is_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, err_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // Close and error results stand alone, so they always end their word group.
    a_close_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg != KIND_DATA) |-> last_reg)
        else $error("close or error result without last");

    // A multibyte job keeps its place at the head until its final byte leaves.
    a_idx_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (idx_reg == 2'd0))
        else $error("byte index not rewound after job completion");

    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("output word changed while the receiver stalled");

endmodule

// File: rtl/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Decodes a JSON string token into raw UTF-8 bytes plus close and error marks.
//
// Usage: feed the token one byte per word on the s_ channel, starting with
// the opening quote; s_tuser high marks end of text (no byte carried). Each
// input word yields zero to four result words on the m_ channel: m_tuser
// gives the kind (data, close, error), m_tdata the byte and error code, and
// m_tlast flags the final result of that input word.
// A result passes from the parser through the job queue into the output
// register. The parser takes one word every cycle; the output sequencer gives
// one result word per cycle while m_tready is high, so a \u escape that expands
// to several UTF-8 bytes drains through the job queue at one byte a cycle while
// parsing carries on. s_tready drops only when that queue is full.
// Reset (aresetn low, synchronous) empties the queue and the output register
// and returns the parser to waiting for an opening quote. When the receiver
// stalls, the output word holds and the queue absorbs up to QUEUE_DEPTH jobs.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte [7:0]
    input  logic        s_tuser,   // end_flag [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte [7:0], error_code [11:8], zero [15:12]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast    // last
);

    push_t push;
    logic  queue_full;
    logic  pop;
    logic  rd_valid;
    job_t  rd_data;

    jsu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .full     (queue_full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: bench/json_string_unescape_utf8_unit_check.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit_check
// Watches both channels of the JSON string unescaper. Each accepted input
// word goes through a bit-exact model of the decoder. Every result word it
// predicts is queued, and every result word taken from the block is compared
// field by field with the oldest queued prediction. It hands the mismatch
// count and the number of predictions still waiting to the bench top.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit_check
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte [7:0]
    input  logic        s_tuser,   // end_flag [0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // out_byte [7:0], error_code [11:8], zero [15:12]
    input  logic [1:0]  m_tuser,   // kind [1:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [3:0] code;
        logic       last;
    } decoded_t;

    decoded_t decoded_q[$];
    decoded_t word_buf[4];
    decoded_t head;
    int       word_n;
    int       mismatches = 0;
    int       word_idx = 0;

    // Decoder state.
    mode_t       mode;
    logic [15:0] hex_acc;
    logic [1:0]  digit_cnt;
    logic [9:0]  high_bits;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    task automatic emit(input logic [7:0] data, input kind_t kind, input logic [3:0] code);
        if (word_n < 4) begin
            word_buf[word_n] = '{data: data, kind: kind, code: code, last: 1'b0};
            word_n++;
        end
    endtask

    task automatic abort_string(input logic [3:0] code);
        emit(8'h00, KIND_ERROR, code);
        mode      = MODE_WAIT;
        hex_acc   = '0;
        digit_cnt = '0;
        high_bits = '0;
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(cp[7:0], KIND_DATA, ERR_NONE);
        end else if (cp < 21'h800) begin
            emit(8'hC0 | 8'(cp >> 6), KIND_DATA, ERR_NONE);
            emit(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
        end else if (cp < 21'h10000) begin
            emit(8'hE0 | 8'(cp >> 12), KIND_DATA, ERR_NONE);
            emit(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_NONE);
            emit(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
        end else begin
            emit(8'hF0 | 8'((cp >> 18) & 21'h07), KIND_DATA, ERR_NONE);
            emit(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA, ERR_NONE);
            emit(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_NONE);
            emit(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
        end
    endtask

    // Advances the decoder by one input word and queues the words it yields.
    task automatic decode_word(input logic [7:0] c, input logic at_end);
        int          nib;
        logic [20:0] cp;
        word_n = 0;
        nib    = nibble_of(c);
        case (mode)
            MODE_STR: begin
                if (at_end) begin
                    abort_string(ERR_UNTERM);
                end else if (c == CH_QUOTE) begin
                    emit(8'h00, KIND_CLOSE, ERR_NONE);
                    mode = MODE_WAIT;
                end else if (c == CH_BSLASH) begin
                    mode = MODE_ESC;
                end else if (c < CH_SPACE) begin
                    abort_string(ERR_CTRL);
                end else begin
                    emit(c, KIND_DATA, ERR_NONE);
                end
            end
            MODE_ESC: begin
                if (at_end) begin
                    abort_string(ERR_ESC_END);
                end else begin
                    mode = MODE_STR;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit(c, KIND_DATA, ERR_NONE);
                        CH_B: emit(8'h08, KIND_DATA, ERR_NONE);
                        CH_F: emit(8'h0C, KIND_DATA, ERR_NONE);
                        CH_N: emit(8'h0A, KIND_DATA, ERR_NONE);
                        CH_R: emit(8'h0D, KIND_DATA, ERR_NONE);
                        CH_T: emit(8'h09, KIND_DATA, ERR_NONE);
                        CH_U: begin
                            mode      = MODE_HEX;
                            hex_acc   = '0;
                            digit_cnt = '0;
                        end
                        default: abort_string(ERR_BAD_ESC);
                    endcase
                end
            end
            MODE_HEX, MODE_LOW_HEX: begin
                if (at_end) begin
                    abort_string(mode == MODE_HEX ? ERR_SHORT_HEX : ERR_NO_LOW);
                end else if (nib < 0) begin
                    abort_string(ERR_BAD_HEX);
                end else begin
                    hex_acc = {hex_acc[11:0], nib[3:0]};
                    if (digit_cnt != 2'd3) begin
                        digit_cnt++;
                    end else begin
                        digit_cnt = '0;
                        if (mode == MODE_HEX) begin
                            if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                                high_bits = hex_acc[9:0];
                                mode      = MODE_LOW_BS;
                            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                                abort_string(ERR_LONE_LOW);
                            end else begin
                                emit_utf8({5'd0, hex_acc});
                                mode = MODE_STR;
                            end
                        end else begin
                            if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                                abort_string(ERR_BAD_LOW);
                            end else begin
                                cp = 21'h10000 + {high_bits, hex_acc[9:0]};
                                emit_utf8(cp);
                                mode = MODE_STR;
                            end
                        end
                        hex_acc = '0;
                    end
                end
            end
            MODE_LOW_BS: begin
                if (at_end || c != CH_BSLASH) abort_string(ERR_NO_LOW);
                else mode = MODE_LOW_U;
            end
            MODE_LOW_U: begin
                if (at_end || c != CH_U) begin
                    abort_string(ERR_NO_LOW);
                end else begin
                    mode      = MODE_LOW_HEX;
                    hex_acc   = '0;
                    digit_cnt = '0;
                end
            end
            default: begin
                if (!at_end && c == CH_QUOTE) begin
                    mode      = MODE_STR;
                    hex_acc   = '0;
                    digit_cnt = '0;
                    high_bits = '0;
                end else begin
                    abort_string(ERR_NO_OPEN);
                end
            end
        endcase
        for (int i = 0; i < word_n; i++) begin
            word_buf[i].last = (i == word_n - 1);
            decoded_q.insert(decoded_q.size(), word_buf[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        mismatches++;
        $display("result word %0d: %s is %h, expected %h", word_idx, what, got, exp_val);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode      = MODE_WAIT;
            hex_acc   = '0;
            digit_cnt = '0;
            high_bits = '0;
            decoded_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                decode_word(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("word with nothing expected, tdata", m_tdata, 16'h0);
                end else begin
                    head = decoded_q.pop_front();
                    if (m_tuser !== head.kind)
                        report_mismatch("kind", 16'(m_tuser), 16'(head.kind));
                    if (m_tdata[7:0] !== head.data)
                        report_mismatch("byte", 16'(m_tdata[7:0]), 16'(head.data));
                    if (m_tdata[11:8] !== head.code)
                        report_mismatch("error code", 16'(m_tdata[11:8]), 16'(head.code));
                    if (m_tdata[15:12] !== 4'd0)
                        report_mismatch("pad bits", 16'(m_tdata[15:12]), 16'h0);
                    if (m_tlast !== head.last)
                        report_mismatch("last flag", 16'(m_tlast), 16'(head.last));
                end
                word_idx++;
            end
        end
        fail_count  <= mismatches;
        outstanding <= decoded_q.size();
    end

endmodule

// File: bench/json_string_unescape_utf8_unit_test.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit_test
// Bench top for the JSON string unescaper. It feeds a directed set of tokens
// covering every escape, every UTF-8 length and every error path, then
// random well-formed and broken tokens with noise between them. Both sides
// idle in short random bursts, and once the receiver holds off long enough
// to back the block up. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit_test;
    import jsu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 280;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                                CH_B, CH_F, CH_N, CH_R, CH_T};

    typedef struct packed {
        logic [7:0] data;
        logic       at_end;
    } text_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          outstanding;

    text_word_t text_q[$];
    bit         quiet = 1'b0;
    bit         hold_request = 1'b0;

    always #5 aclk = ~aclk;

    json_string_unescape_utf8_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    json_string_unescape_utf8_unit_check chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    task automatic put(input logic [7:0] c);
        text_q.insert(text_q.size(), text_word_t'{data: c, at_end: 1'b0});
    endtask

    // End of text; the byte lane carries junk that the block must ignore.
    task automatic put_end(input logic [7:0] c);
        text_q.insert(text_q.size(), text_word_t'{data: c, at_end: 1'b1});
    endtask

    // Emits the top digits of v, letters in random case.
    task automatic put_hex(input logic [15:0] v, input int count);
        logic [3:0] d;
        for (int k = 3; k > 3 - count; k--) begin
            d = v[k*4 +: 4];
            if (d < 4'd10) put(8'h30 + d);
            else if ($urandom_range(0, 1) != 0) put(8'h61 + d - 8'd10);
            else put(8'h41 + d - 8'd10);
        end
    endtask

    task automatic put_u(input logic [15:0] v);
        put(CH_BSLASH);
        put(CH_U);
        put_hex(v, 4);
    endtask

    task automatic put_bad_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_hex(c));
        put(c);
    endtask

    // Receiver: short random stalls, one long hold-off on request, none at the end.
    initial begin : receiver
        int  cyc;
        bit  stall_on;
        cyc      = 0;
        stall_on = 1'b1;
        forever begin
            if (cyc % 50 == 0) stall_on = ($urandom_range(0, 2) != 0);
            cyc++;
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (stall_on && !quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        int          n_directed;
        int          quiet_from;
        int          hold_at;
        int          sel;
        int          r;
        int          k;
        bit          gaps_on;
        logic [7:0]  c;
        logic [15:0] v;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed tokens.
        put_end(8'h00);                             // end of text while waiting
        put(8'hFF);                                 // stray byte while waiting
        put(CH_QUOTE); put(CH_SPACE); put(8'hFF); put(8'h7F); put(8'h80); put(CH_QUOTE);
        put(CH_QUOTE);
        foreach (ESC_LETTERS[e]) begin
            put(CH_BSLASH);
            put(ESC_LETTERS[e]);
        end
        put(CH_QUOTE);
        // One to four UTF-8 bytes at the edges of each length, null included.
        put(CH_QUOTE);
        put_u(16'h0000); put_u(16'h007F); put_u(16'h0080); put_u(16'h07FF);
        put_u(16'h0800); put_u(16'hFFFF);
        put_u(16'hD800); put_u(16'hDC00); put_u(16'hDBFF); put_u(16'hDFFF);
        put(CH_QUOTE);
        put(CH_QUOTE); put(8'h00);
        put(CH_QUOTE); put(8'h1F);
        put(CH_QUOTE); put(CH_BSLASH); put("q");
        put(CH_QUOTE); put_end(CH_QUOTE);
        put(CH_QUOTE); put(CH_BSLASH); put_end(8'hFF);
        put(CH_QUOTE); put(CH_BSLASH); put(CH_U); put_hex(16'h1200, 2); put_end(8'h30);
        // High surrogate cut short at each point of the second escape.
        put(CH_QUOTE); put_u(16'hD800); put_end(8'h5C);
        put(CH_QUOTE); put_u(16'hD800); put(CH_BSLASH); put_end(8'h75);
        put(CH_QUOTE); put_u(16'hD800); put(CH_BSLASH); put(CH_U); put_end(8'h44);
        put(CH_QUOTE); put_u(16'hD800); put(CH_BSLASH); put(CH_U); put_hex(16'hDC00, 2);
        put_end(8'h30);
        put(CH_QUOTE); put(CH_BSLASH); put(CH_U); put("1"); put("G");
        put(CH_QUOTE); put_u(16'hD83D); put(CH_BSLASH); put(CH_U); put_hex(16'hDE00, 2);
        put("Z");
        put(CH_QUOTE); put_u(16'hD800); put("x");
        put(CH_QUOTE); put_u(16'hD800); put(CH_BSLASH); put("x");
        put(CH_QUOTE); put_u(16'hD800); put_u(16'h0041);
        put(CH_QUOTE); put_u(16'hDBFF); put_u(16'hE000);
        put(CH_QUOTE); put_u(16'hDC00);
        put(CH_QUOTE); put_u(16'hDFFF);
        put_end(CH_QUOTE);                          // a quote on an end word opens nothing
        n_directed = text_q.size();

        // Random tokens: mostly well formed, some broken, a little raw noise.
        while (text_q.size() < n_directed + RANDOM_WORDS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 5) == 0) put_end(8'($urandom_range(0, 255)));
                    else put(8'($urandom_range(0, 255)));
                end
            end else begin
                put(CH_QUOTE);
                repeat ($urandom_range(0, 10)) begin
                    r = $urandom_range(0, 8);
                    if (r <= 4) begin
                        do c = 8'($urandom_range(8'h20, 8'hFF));
                        while (c == CH_QUOTE || c == CH_BSLASH);
                        put(c);
                    end else if (r == 5) begin
                        put(CH_BSLASH);
                        put(ESC_LETTERS[$urandom_range(0, 7)]);
                    end else if (r <= 7) begin
                        case ($urandom_range(0, 2))
                            0: v = 16'($urandom_range(0, 16'h7F));
                            1: v = 16'($urandom_range(16'h80, 16'h7FF));
                            default: begin
                                // Skip the surrogate range.
                                v = 16'($urandom_range(16'h800, 16'hF7FF));
                                if (v >= 16'hD800) v = v + 16'h800;
                            end
                        endcase
                        put_u(v);
                    end else begin
                        put_u(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
                        put_u(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
                    end
                end
                if (sel >= 3) begin
                    put(CH_QUOTE);
                end else begin
                    case ($urandom_range(0, 8))
                        0: put_end(8'($urandom_range(0, 255)));
                        1: put(8'($urandom_range(0, 8'h1F)));
                        2: begin
                            put(CH_BSLASH);
                            do c = 8'($urandom_range(0, 255));
                            while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F,
                                             CH_N, CH_R, CH_T, CH_U});
                            put(c);
                        end
                        3: begin
                            put(CH_BSLASH); put(CH_U);
                            put_hex(16'($urandom), $urandom_range(0, 3));
                            put_bad_hex();
                        end
                        4: begin
                            put(CH_BSLASH); put(CH_U);
                            put_hex(16'($urandom), $urandom_range(0, 3));
                            put_end(8'($urandom_range(0, 255)));
                        end
                        5: begin
                            put(CH_BSLASH);
                            put_end(8'($urandom_range(0, 255)));
                        end
                        6: begin
                            put_u(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
                            case ($urandom_range(0, 4))
                                0: begin
                                    do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
                                    put(c);
                                end
                                1: begin
                                    put(CH_BSLASH);
                                    do c = 8'($urandom_range(0, 255)); while (c == CH_U);
                                    put(c);
                                end
                                2: begin
                                    k = $urandom_range(0, 5);
                                    if (k >= 1) put(CH_BSLASH);
                                    if (k >= 2) put(CH_U);
                                    if (k >= 3) put_hex(16'($urandom), k - 2);
                                    put_end(8'($urandom_range(0, 255)));
                                end
                                3: begin
                                    do v = 16'($urandom);
                                    while (v >= 16'hDC00 && v <= 16'hDFFF);
                                    put_u(v);
                                end
                                default: begin
                                    put(CH_BSLASH); put(CH_U);
                                    put_hex(16'hDC00 + 16'($urandom_range(0, 16'h3FF)),
                                            $urandom_range(0, 3));
                                    put_bad_hex();
                                end
                            endcase
                        end
                        7: put_u(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
                        default: begin
                            if ($urandom_range(0, 1) != 0) put_end(8'($urandom_range(0, 255)));
                            else put(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
            end
        end

        quiet_from = text_q.size() - text_q.size() / 8;
        hold_at    = n_directed + 40;
        gaps_on    = 1'b1;
        for (int i = 0; i < text_q.size(); i++) begin
            if (i % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (i == quiet_from) quiet = 1'b1;
            if (i == hold_at) hold_request = 1'b1;
            if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i].data;
            s_tuser  <= text_q[i].at_end;
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;

        // Let the last words drain, then give extra results a chance to show.
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** json_string_unescape_utf8_unit: PASSED **");
        end else begin
            $display("** json_string_unescape_utf8_unit: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("** json_string_unescape_utf8_unit: FAILED **");
        $finish;
    end

endmodule
